### sv/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache unit.
// No dependencies; every other file imports this package.
package lkvc_pkg;

  localparam int unsigned CFG_W = 5;
  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;
  localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_UPDATE,
    ST_RESP
  } ctrl_state_e;

  typedef struct packed {
    logic start;
    logic scan;
    logic update;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } status_t;

endpackage

### sv/lkvc_ctrl.sv
// Sequencer for the LRU key-value cache: accept, scan, flush, update, respond.
// Depends on lkvc_pkg for the state type and the command/status structs.
module lkvc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lkvc_pkg::status_t status_i,
  output lkvc_pkg::cmd_t    cmd_o
);
  import lkvc_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN:   if (status_i.scan_last) state_d = ST_FLUSH;
      ST_FLUSH:  state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_RESP;
      ST_RESP:   if (status_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = (state_q == ST_IDLE);
    cmd_o.start    = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.scan     = (state_q == ST_SCAN);
    cmd_o.update   = (state_q == ST_UPDATE);
    cmd_o.load_out = (state_q == ST_RESP) && status_i.out_free;
  end

  // result register must be free when loaded
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> status_i.out_free)
    else $error("result loaded while output word still held");

  a_start_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> state_q == ST_SCAN)
    else $error("accepted word did not start a scan");

  a_update_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) |=> (state_q == ST_RESP))
    else $error("update not followed by response");

endmodule

### sv/lkvc_datapath.sv
// Datapath of the LRU key-value cache: key/value memories, valid bits,
// recency ranks, scan trackers and result register. Depends on lkvc_pkg.
module lkvc_datapath #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lkvc_pkg::cmd_t             cmd_i,
  output lkvc_pkg::status_t          status_o,
  input  logic                       cfg_we_i,
  input  logic [lkvc_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                       req_type_i,
  input  logic signed [31:0]         key_i,
  input  logic signed [31:0]         new_value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       hit_o,
  output logic signed [31:0]         read_value_o
);
  import lkvc_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned RW = IW;
  localparam int unsigned FW = $clog2(ENTRIES + 1);
  localparam int unsigned CW = (FW > CFG_W) ? FW : CFG_W;

  logic [31:0]      key_mem [ENTRIES];
  logic [31:0]      val_mem [ENTRIES];

  logic [CFG_W-1:0] capacity_q;
  logic             req_put_q;
  logic [31:0]      req_key_q, req_val_q;
  logic [IW-1:0]    scan_idx_q, cmp_idx_q;
  logic             cmp_en_q;
  logic [31:0]      krd_q, vrd_q;
  logic             found_q, have_free_q, have_vic_q;
  logic [IW-1:0]    match_q, free_q, vic_q;
  logic [RW-1:0]    match_rank_q, vic_rank_q;
  logic [ENTRIES-1:0] valid_q;
  logic [RW-1:0]    rank_q [ENTRIES];
  logic [FW-1:0]    fill_q;
  logic             out_valid_q, hit_q;
  logic [31:0]      rv_q;

  logic             cmp_valid, key_eq;
  logic [RW-1:0]    cmp_rank;
  logic [CW-1:0]    cap_w, eff_cap;
  logic             evict, do_touch, do_insert, wr_key;
  logic [IW-1:0]    wr_slot;
  logic [RW-1:0]    touch_rank;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  // clamp capacity into 1..ENTRIES
  always_comb begin
    cap_w = CW'(capacity_q);
    if (cap_w == '0) begin
      eff_cap = CW'(1);
    end else if (cap_w > CW'(ENTRIES)) begin
      eff_cap = CW'(ENTRIES);
    end else begin
      eff_cap = cap_w;
    end
  end

  assign cmp_valid = valid_q[cmp_idx_q];
  assign cmp_rank  = rank_q[cmp_idx_q];
  assign key_eq    = (krd_q == req_key_q);

  always_comb begin
    evict      = (CW'(fill_q) >= eff_cap);
    do_touch   = found_q || (req_put_q && evict);
    do_insert  = req_put_q && !found_q && !evict;
    wr_key     = req_put_q && !found_q;
    wr_slot    = found_q ? match_q : (evict ? vic_q : free_q);
    touch_rank = found_q ? match_rank_q : vic_rank_q;
  end

  // request latch and scan trackers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_en_q    <= 1'b0;
      found_q     <= 1'b0;
      have_free_q <= 1'b0;
      have_vic_q  <= 1'b0;
      scan_idx_q  <= '0;
    end else begin
      cmp_en_q <= cmd_i.scan;
      if (cmd_i.start) begin
        found_q     <= 1'b0;
        have_free_q <= 1'b0;
        have_vic_q  <= 1'b0;
        scan_idx_q  <= '0;
      end else begin
        if (cmd_i.scan) scan_idx_q <= scan_idx_q + 1'b1;
        if (cmp_en_q) begin
          if (cmp_valid && key_eq && !found_q) found_q <= 1'b1;
          if (!cmp_valid) have_free_q <= 1'b1;
          if (cmp_valid) have_vic_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_put_q <= (req_type_i == REQ_PUT);
      req_key_q <= key_i;
      req_val_q <= new_value_i;
    end
    cmp_idx_q <= scan_idx_q;
    if (cmp_en_q) begin
      if (cmp_valid && key_eq && !found_q) begin
        match_q      <= cmp_idx_q;
        match_rank_q <= cmp_rank;
      end
      if (!cmp_valid && !have_free_q) free_q <= cmp_idx_q;
      if (cmp_valid && (!have_vic_q || cmp_rank > vic_rank_q)) begin
        vic_q      <= cmp_idx_q;
        vic_rank_q <= cmp_rank;
      end
    end
  end

  // key and value memories, registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.update && wr_key) key_mem[wr_slot] <= req_key_q;
    krd_q <= key_mem[scan_idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update && req_put_q) val_mem[wr_slot] <= req_val_q;
    vrd_q <= val_mem[match_q];
  end

  // valid bits, recency ranks and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fill_q  <= '0;
      for (int i = 0; i < ENTRIES; i++) rank_q[i] <= '0;
    end else if (cmd_i.update) begin
      if (do_insert) begin
        fill_q <= fill_q + 1'b1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (IW'(i) == wr_slot) begin
            rank_q[i]  <= '0;
            valid_q[i] <= 1'b1;
          end else if (valid_q[i]) begin
            rank_q[i] <= rank_q[i] + 1'b1;
          end
        end
      end else if (do_touch) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (IW'(i) == wr_slot) begin
            rank_q[i] <= '0;
          end else if (valid_q[i] && rank_q[i] < touch_rank) begin
            rank_q[i] <= rank_q[i] + 1'b1;
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      hit_q <= found_q;
      rv_q  <= (!req_put_q && found_q) ? vrd_q : MISS_VALUE;
    end
  end

  assign status_o.scan_last = (scan_idx_q == IW'(ENTRIES - 1));
  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign read_value_o = rv_q;

  a_fill_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == fill_q)
    else $error("fill count disagrees with valid bits");

  a_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(ENTRIES))
    else $error("fill count beyond store size");

  a_insert_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.update && do_insert) |-> (have_free_q && !valid_q[free_q]))
    else $error("insert aimed at an occupied slot");

endmodule

### sv/lru_key_value_cache_unit.sv
// Top level of the LRU key-value cache unit.
// Instantiates lkvc_ctrl and lkvc_datapath; depends on lkvc_pkg.

// Fully associative key-value cache with least-recently-used replacement.
// Each input word is a get (req_type 0) or a put (req_type 1) on a signed
// 32-bit key; each produces exactly one output word carrying hit (key was
// present before the request) and read_value (stored value on a get hit,
// all ones, i.e. -1, on a get miss and for every put). The capacity
// register limits how many entries are used before eviction starts; 0 acts
// as 1 and values above ENTRIES act as ENTRIES. Lowering it below the
// current fill does not drop entries: new keys simply replace the least
// recent one from then on. Write capacity only while the unit is idle.
// Once accepted, a request goes through scan, flush, update and response: the
// key memory has a single read port, so the lookup scans one entry per cycle,
// a flush step drains the compare stage, the update step writes the store and
// ranks and the response step loads the result register.
// A new word is accepted while a previous result still waits to be taken;
// the unit only stalls in its response step if that result is unclaimed.
// Valid bits and ranks clear at reset, so no clearing pass is needed.
module lru_key_value_cache_unit #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lkvc_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       req_type_i,
  input  logic signed [31:0]         key_i,
  input  logic signed [31:0]         new_value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       hit_o,
  output logic signed [31:0]         read_value_o
);
  import lkvc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer: owns the input handshake, drives datapath commands
  lkvc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // store, ranks and result register
  lkvc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_type_i   (req_type_i),
    .key_i        (key_i),
    .new_value_i  (new_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hit_o        (hit_o),
    .read_value_o (read_value_o)
  );

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for lru_key_value_cache_unit: directed and random get/put words
// checked against a recency-ranked model of the store. Depends on lkvc_pkg and the RTL.

module tb;
  import lkvc_pkg::*;

  localparam int unsigned SLOTS = 16;
  // Span of one word from accept to the next accept, with no receiver stall.
  localparam int unsigned WORD_CYCLES = SLOTS + 4;
  // Cycles with no word moving on either side before the run is declared hung.
  // The slowest legal stretch is the long receiver hold-off plus one word.
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned HOLD_OFF = 400;
  localparam int unsigned PHASE_WORDS = 200;

  typedef struct packed {
    logic        hit;
    logic [31:0] value;
  } lookup_t;

  // Scoreboard: mirrors the cache contents and recency order, holds the
  // results still owed by the block and compares what comes out.
  class cache_tracker;
    logic [31:0]      slot_key [SLOTS];
    logic [31:0]      slot_val [SLOTS];
    bit               slot_used [SLOTS];
    int unsigned      slot_age [SLOTS];
    int unsigned      fill;
    logic [CFG_W-1:0] capacity;
    lookup_t          awaited_results [$];
    int unsigned      errors, checked, gets, puts, hits, evictions, cap_writes;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        slot_used[i] = 1'b0;
        slot_age[i] = 0;
      end
      fill = 0;
      capacity = CAP_RESET;
      errors = 0;
      checked = 0;
      gets = 0;
      puts = 0;
      hits = 0;
      evictions = 0;
      cap_writes = 0;
    endfunction

    function void set_capacity(logic [CFG_W-1:0] v);
      capacity = v;
      cap_writes++;
    endfunction

    function int unsigned pending();
      return awaited_results.size();
    endfunction

    // Make slot s most recent; entries that were more recent move down one.
    function void promote(int unsigned s);
      int unsigned r;
      r = slot_age[s];
      for (int unsigned i = 0; i < SLOTS; i++)
        if (slot_used[i] && i != s && slot_age[i] < r) slot_age[i]++;
      slot_age[s] = 0;
    endfunction

    // Work out the result of one accepted word and update the mirrored store.
    function void note_request(logic is_put, logic [31:0] key, logic [31:0] val);
      int unsigned limit;
      int unsigned slot;
      bit          found;
      bit          have;
      lookup_t     res;
      limit = (capacity == 0) ? 1 : ((capacity > SLOTS) ? SLOTS : capacity);
      found = 1'b0;
      slot = 0;
      for (int unsigned i = 0; i < SLOTS; i++)
        if (!found && slot_used[i] && slot_key[i] == key) begin
          slot = i;
          found = 1'b1;
        end
      res.hit = found;
      res.value = MISS_VALUE;
      if (found) hits++;
      if (is_put == REQ_GET) begin
        gets++;
        if (found) begin
          res.value = slot_val[slot];
          promote(slot);
        end
      end else begin
        puts++;
        if (found) begin
          slot_val[slot] = val;
          promote(slot);
        end else if (fill >= limit) begin
          // Full (or capacity lowered below fill): replace the oldest entry.
          have = 1'b0;
          for (int unsigned i = 0; i < SLOTS; i++)
            if (slot_used[i] && (!have || slot_age[i] > slot_age[slot])) begin
              slot = i;
              have = 1'b1;
            end
          slot_key[slot] = key;
          slot_val[slot] = val;
          promote(slot);
          evictions++;
        end else begin
          have = 1'b0;
          for (int unsigned i = 0; i < SLOTS; i++)
            if (!have && !slot_used[i]) begin
              slot = i;
              have = 1'b1;
            end
          for (int unsigned i = 0; i < SLOTS; i++)
            if (slot_used[i]) slot_age[i]++;
          slot_key[slot] = key;
          slot_val[slot] = val;
          slot_used[slot] = 1'b1;
          slot_age[slot] = 0;
          fill++;
        end
      end
      awaited_results.push_back(res);
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(logic hit, logic [31:0] value);
      lookup_t want;
      checked++;
      if (awaited_results.size() == 0) begin
        report($sformatf("result with nothing owed: hit=%0b value=%h", hit, value));
        return;
      end
      want = awaited_results.pop_front();
      if (hit !== want.hit)
        report($sformatf("result %0d hit=%0b, wanted %0b", checked, hit, want.hit));
      if (value !== want.value)
        report($sformatf("result %0d read_value=%h, wanted %h", checked, value, want.value));
    endtask
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_W-1:0]        cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    req_type_i;
  logic signed [31:0]      key_i;
  logic signed [31:0]      new_value_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic                    hit_o;
  logic signed [31:0]      read_value_o;

  cache_tracker tracker;
  logic [31:0]  key_pool [$];
  int unsigned  burst_left;
  int unsigned  quiet;
  bit           steady;      // sender offers back to back, no gaps
  bit           squeeze_req; // ask the receiver for its long hold-off
  bit           squeezed;

  lru_key_value_cache_unit #(.ENTRIES(SLOTS)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .key_i        (key_i),
    .new_value_i  (new_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hit_o        (hit_o),
    .read_value_o (read_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Offer one word and hold it until the block takes it. Unless steady is set,
  // the sender works in bursts: when a burst runs out, drop valid for a random
  // gap first (or none at all), then start a new burst. Returns at the accepting
  // edge so the next word can follow without a bubble.
  task automatic issue(logic is_put, logic [31:0] key, logic [31:0] val);
    int unsigned gap;
    if (!steady && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left != 0) burst_left--;
    in_valid_i  <= 1'b1;
    req_type_i  <= is_put;
    key_i       <= key;
    new_value_i <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.note_request(is_put, key, val);
  endtask

  // Write the capacity register once every owed result has come back. Every
  // word yields a result, so an empty queue means the block is idle.
  task automatic write_capacity(logic [CFG_W-1:0] v);
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_capacity(v);
  endtask

  // Corner values turn up often in both keys and data.
  function automatic logic [31:0] corner_or_random();
    case ($urandom_range(0, 9))
      0:       return 32'hFFFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly reuse a small key set so gets hit and puts update or evict;
  // now and then throw in a fresh random key.
  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 99) < 85)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    return $urandom;
  endfunction

  // One random phase: set the capacity, build a key set of the given size and
  // send a mix of gets and puts drawn from it.
  task automatic run_phase(logic [CFG_W-1:0] cap, int unsigned pool_size);
    write_capacity(cap);
    key_pool.delete();
    repeat (pool_size) key_pool.push_back(corner_or_random());
    repeat (PHASE_WORDS)
      issue(($urandom_range(0, 1) != 0) ? REQ_PUT : REQ_GET, pick_key(),
            corner_or_random());
  endtask

  // Receiver: stall on a pattern of runs - always ready, fully stalled, coin
  // toss per cycle, or mostly ready. Once asked, and only while the sender is
  // offering, hold off for a long stretch so the block fills up and
  // back-pressures the sender.
  initial begin
    int unsigned mode;
    int unsigned len;
    logic        level;
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (squeeze_req && !squeezed && in_valid_i) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk_i);
        squeezed = 1'b1;
      end
      mode = $urandom_range(0, 3);
      len = $urandom_range(1, 40);
      repeat (len) begin
        case (mode)
          0:       level = 1'b1;
          1:       level = 1'b0;
          2:       level = $urandom_range(0, 1);
          default: level = ($urandom_range(0, 3) != 0);
        endcase
        out_ready_i <= level;
        @(posedge clk_i);
      end
    end
  end

  // Check every result word taken by the receiver against the oldest owed one.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) tracker.check_result(hit_o, read_value_o);
  end

  // Watchdog: count cycles in which no word moves on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
    else if (rst_ni) quiet++;
    if (quiet == IDLE_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles", IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    tracker = new();
    quiet = 0;
    burst_left = 0;
    steady = 1'b0;
    squeeze_req = 1'b0;
    squeezed = 1'b0;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    req_type_i  <= REQ_GET;
    key_i       <= '0;
    new_value_i <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, reset capacity: miss on an empty store, key -1 used as an
    // ordinary key, the signed extremes as keys and data, a stored value of -1
    // that must still report a hit, and an update of a present key.
    issue(REQ_GET, 32'h0000_0000, 32'h1234_5678);
    issue(REQ_PUT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    issue(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    issue(REQ_PUT, 32'h8000_0000, 32'h8000_0000);
    issue(REQ_PUT, 32'h7FFF_FFFF, 32'h0000_0000);
    issue(REQ_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    issue(REQ_GET, 32'h0000_0000, 32'h0000_0000);
    issue(REQ_PUT, 32'hFFFF_FFFF, 32'h1234_5678);
    issue(REQ_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    issue(REQ_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    issue(REQ_GET, 32'h0000_0001, 32'h0000_0000);

    // Lower capacity below the fill: new keys replace the oldest entry while
    // existing entries stay reachable.
    write_capacity(5'd2);
    issue(REQ_PUT, 32'h0000_0005, 32'h0000_0037);
    issue(REQ_GET, 32'h0000_0000, 32'h0000_0000);
    issue(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    issue(REQ_PUT, 32'h0000_0006, 32'h5555_AAAA);
    issue(REQ_GET, 32'h8000_0000, 32'h0000_0000);

    // Capacity zero behaves as one.
    write_capacity(5'd0);
    issue(REQ_PUT, 32'h0000_0007, 32'hAAAA_5555);
    issue(REQ_GET, 32'h0000_0007, 32'h0000_0000);
    issue(REQ_GET, 32'h0000_0006, 32'h0000_0000);
    issue(REQ_PUT, 32'h0000_0008, 32'hDEAD_BEEF);
    issue(REQ_GET, 32'h0000_0007, 32'h0000_0000);

    // Random phases; capacity above the store size acts as the store size.
    run_phase(5'd31, 20);
    run_phase(5'd1, 3);
    // Pressure phase: receiver holds off while the sender keeps offering.
    steady = 1'b1;
    squeeze_req = 1'b1;
    run_phase(5'd16, 18);
    steady = 1'b0;
    run_phase(5'd0, 2);
    run_phase(5'($urandom_range(2, 15)), 12);
    run_phase(5'd16, 40);
    run_phase(5'd3, 5);
    run_phase(5'($urandom_range(0, 31)), 10);
    run_phase(5'd8, 9);

    // Drain, then leave room for any stray result to show up.
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (2 * WORD_CYCLES) @(posedge clk_i);

    $display("Covered %0d gets and %0d puts over %0d capacity writes: %0d hits, %0d evictions",
             tracker.gets, tracker.puts, tracker.cap_writes, tracker.hits, tracker.evictions);
    $display("Compared %0d result words, %0d mismatches", tracker.checked, tracker.errors);
    if (tracker.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
